// ===== rtl/dbds_pkg.sv =====
// Shared types, constants and codes for the double-buffered dedup set unit.
package dbds_pkg;

   // Sizing
   localparam int ENTRY_COUNT = 1024;
   localparam int GEN_BITS    = 8;
   localparam int IDX_W       = $clog2(ENTRY_COUNT);
   localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);
   localparam int ID_W        = 10;
   localparam int OPC_W       = 3;
   localparam int SYNC_W      = 2;
   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   // Opcodes as they arrive on the request port
   localparam logic [OPC_W-1:0] OPC_PUT       = 3'd0;
   localparam logic [OPC_W-1:0] OPC_SWAP      = 3'd1;
   localparam logic [OPC_W-1:0] OPC_REMOVE    = 3'd2;
   localparam logic [OPC_W-1:0] OPC_CLEAR     = 3'd3;
   localparam logic [OPC_W-1:0] OPC_READ_CUR  = 3'd4;
   localparam logic [OPC_W-1:0] OPC_READ_NEXT = 3'd5;

   // Sync state codes
   localparam logic [SYNC_W-1:0] SYNC_NONE = 2'd0;
   localparam logic [SYNC_W-1:0] SYNC_ONE  = 2'd1;
   localparam logic [SYNC_W-1:0] SYNC_MANY = 2'd2;

   // Decoded command kinds handed from front to back
   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_SWAP,
      CMD_REMOVE,
      CMD_CLEAR,
      CMD_READ_CUR,
      CMD_READ_NEXT,
      CMD_NOP
   } cmd_kind_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PUT_WR,
      ST_READ,
      ST_RM_LIST,
      ST_RM_MARK,
      ST_RM_PUT
   } back_state_type;

   typedef struct packed {
      logic [OPC_W-1:0] opcode;
      logic [ID_W-1:0]  entry_id;
      logic [ID_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic              was_added;
      logic [CNT_W-1:0]  current_count;
      logic [CNT_W-1:0]  next_count;
      logic [SYNC_W-1:0] sync_state;
      logic [ID_W-1:0]   first_current;
      logic [ID_W-1:0]   first_next;
      logic [ID_W-1:0]   read_value;
      logic              read_valid;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] index;
   } cmd_type;

endpackage

// ===== rtl/double_buffered_dedup_set_unit.sv =====
// Swap, clear and unused ops register their result as they are taken; put and read pass ST_PUT_WR or ST_READ first.
// Remove walks the current list, taking each entry through ST_RM_LIST, ST_RM_MARK and ST_RM_PUT.
// A put or read ends before the next command is taken; a put reads the mark store, then writes it.
// A clear or a generation wrap starts a sweep of all marks as its result is registered.
// Reset (synchronous, active high) empties both lists and starts the same mark
// sweep; up to two requests queue meanwhile, none executes until it ends.
module double_buffered_dedup_set_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dbds_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dbds_pkg::rsp_type rsp_data
);
   import dbds_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd_data;

   // request decode and command queue
   dbds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // execution over list banks and mark store
   dbds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/dbds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dbds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dbds_front.sv =====
// Front end: accepts requests, decodes them and queues commands for the back end.
module dbds_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dbds_pkg::req_type req_data,
   output logic              cmd_valid,
   output dbds_pkg::cmd_type cmd_data,
   input  logic              cmd_take
);
   import dbds_pkg::*;

   cmd_type              q_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 push_xfer;
   logic                 pop_xfer;
   cmd_type              decoded;

   // opcode classification
   always_comb begin
      decoded.id    = req_data.entry_id;
      decoded.index = req_data.read_index;
      unique case (req_data.opcode)
         OPC_PUT:       decoded.kind = CMD_PUT;
         OPC_SWAP:      decoded.kind = CMD_SWAP;
         OPC_REMOVE:    decoded.kind = CMD_REMOVE;
         OPC_CLEAR:     decoded.kind = CMD_CLEAR;
         OPC_READ_CUR:  decoded.kind = CMD_READ_CUR;
         OPC_READ_NEXT: decoded.kind = CMD_READ_NEXT;
         default:       decoded.kind = CMD_NOP;
      endcase
   end

   assign req_full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign push_xfer = req_push && !req_full;
   assign pop_xfer  = cmd_take && cmd_valid;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== rtl/dbds_back.sv =====
// Back end: sequencer over list banks and mark store, builds and holds results.
module dbds_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  dbds_pkg::cmd_type cmd_data,
   output logic              cmd_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dbds_pkg::rsp_type rsp_data
);
   import dbds_pkg::*;

   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     sweep_ff, sweep_in;
   logic [CNT_W-1:0]     cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]     cnt_b_ff, cnt_b_in;
   logic                 cur_b_ff, cur_b_in;
   logic [GEN_BITS-1:0]  gen_ff, gen_in;
   logic [ID_W-1:0]      first_a_ff, first_a_in;
   logic [ID_W-1:0]      first_b_ff, first_b_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [ID_W-1:0]      elem_ff, elem_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                 mark_we, mark_re;
   logic [IDX_W-1:0]     mark_waddr, mark_raddr;
   logic [GEN_BITS-1:0]  mark_wdata, mark_rdata;
   logic                 la_we, la_re, lb_we, lb_re;
   logic [IDX_W-1:0]     la_waddr, la_raddr, lb_waddr, lb_raddr;
   logic [ID_W-1:0]      la_wdata, lb_wdata, la_rdata, lb_rdata;

   // sequencer helpers
   logic                 out_free;
   logic [CNT_W-1:0]     cur_cnt, nxt_cnt, rd_cnt, res_cc, res_nc;
   logic                 put_en, put_ok, swap_en, clear_en;
   logic [ID_W-1:0]      put_id, cur_rdata, rval;
   logic                 res_load, res_added, res_rvalid, rd_sel_b;
   logic [ID_W-1:0]      res_rval;

   dbds_ram #(.WIDTH(GEN_BITS), .DEPTH(ENTRY_COUNT)) u_mark (
      .clock(clock), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
      .re(mark_re), .raddr(mark_raddr), .rdata(mark_rdata)
   );
   dbds_ram #(.WIDTH(ID_W), .DEPTH(ENTRY_COUNT)) u_list_a (
      .clock(clock), .we(la_we), .waddr(la_waddr), .wdata(la_wdata),
      .re(la_re), .raddr(la_raddr), .rdata(la_rdata)
   );
   dbds_ram #(.WIDTH(ID_W), .DEPTH(ENTRY_COUNT)) u_list_b (
      .clock(clock), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
      .re(lb_re), .raddr(lb_raddr), .rdata(lb_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign cur_cnt   = cur_b_ff ? cnt_b_ff : cnt_a_ff;
   assign nxt_cnt   = cur_b_ff ? cnt_a_ff : cnt_b_ff;
   assign cur_rdata = cur_b_ff ? lb_rdata : la_rdata;
   assign rd_sel_b  = (cmd_ff.kind == CMD_READ_CUR) ? cur_b_ff : !cur_b_ff;
   assign rd_cnt    = rd_sel_b ? cnt_b_ff : cnt_a_ff;
   assign rval      = rd_sel_b ? lb_rdata : la_rdata;
   // dedup test: id in range, not marked this generation, room in next list
   assign put_ok    = (32'(put_id) < ENTRY_COUNT) && (mark_rdata != gen_ff)
                      && (32'(nxt_cnt) < ENTRY_COUNT);

   // sequencer: next state, memory controls, state updates, result build
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      cur_b_in     = cur_b_ff;
      gen_in       = gen_ff;
      first_a_in   = first_a_ff;
      first_b_in   = first_b_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      elem_in      = elem_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      cmd_take     = 1'b0;
      mark_we      = 1'b0;
      mark_waddr   = IDX_W'(put_id);
      mark_wdata   = gen_ff;
      mark_re      = 1'b0;
      mark_raddr   = IDX_W'(cmd_data.id);
      la_we        = 1'b0;
      la_waddr     = IDX_W'(nxt_cnt);
      la_wdata     = put_id;
      la_re        = 1'b0;
      la_raddr     = IDX_W'(cmd_data.index);
      lb_we        = 1'b0;
      lb_waddr     = IDX_W'(nxt_cnt);
      lb_wdata     = put_id;
      lb_re        = 1'b0;
      lb_raddr     = IDX_W'(cmd_data.index);
      put_en       = 1'b0;
      put_id       = cmd_ff.id;
      swap_en      = 1'b0;
      clear_en     = 1'b0;
      res_load     = 1'b0;
      res_added    = 1'b0;
      res_rvalid   = 1'b0;
      res_rval     = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            mark_we    = 1'b1;
            mark_waddr = sweep_ff;
            mark_wdata = '0;
            if (sweep_ff == IDX_W'(ENTRY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data;
               unique case (cmd_data.kind)
                  CMD_PUT: begin
                     mark_re  = 1'b1;
                     state_in = ST_PUT_WR;
                  end
                  CMD_SWAP: begin
                     swap_en  = 1'b1;
                     res_load = 1'b1;
                  end
                  CMD_REMOVE: begin
                     pos_in = '0;
                     if (cur_cnt == '0) begin
                        swap_en  = 1'b1;
                        res_load = 1'b1;
                     end else begin
                        state_in = ST_RM_LIST;
                     end
                  end
                  CMD_CLEAR: begin
                     clear_en = 1'b1;
                     res_load = 1'b1;
                  end
                  CMD_READ_CUR, CMD_READ_NEXT: begin
                     la_re    = 1'b1;
                     lb_re    = 1'b1;
                     state_in = ST_READ;
                  end
                  CMD_NOP: begin
                     res_load = 1'b1;
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         ST_PUT_WR: begin
            put_en    = 1'b1;
            res_added = put_ok;
            res_load  = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            res_rvalid = (32'(cmd_ff.index) < 32'(rd_cnt));
            res_rval   = res_rvalid ? rval : '0;
            res_load   = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RM_LIST: begin
            la_re    = !cur_b_ff;
            lb_re    = cur_b_ff;
            la_raddr = IDX_W'(pos_ff);
            lb_raddr = IDX_W'(pos_ff);
            state_in = ST_RM_MARK;
         end
         ST_RM_MARK: begin
            elem_in    = cur_rdata;
            mark_re    = 1'b1;
            mark_raddr = IDX_W'(cur_rdata);
            state_in   = ST_RM_PUT;
         end
         ST_RM_PUT: begin
            put_id = elem_ff;
            put_en = (elem_ff != cmd_ff.id);
            pos_in = pos_ff + 1'b1;
            if ((pos_ff + 1'b1) == cur_cnt) begin
               swap_en  = 1'b1;
               res_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RM_LIST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // append to the next list and mark the id
      if (put_en && put_ok) begin
         mark_we    = 1'b1;
         mark_waddr = IDX_W'(put_id);
         mark_wdata = gen_ff;
         if (cur_b_ff) begin
            la_we    = 1'b1;
            cnt_a_in = cnt_a_ff + 1'b1;
            if (cnt_a_ff == '0) begin
               first_a_in = put_id;
            end
         end else begin
            lb_we    = 1'b1;
            cnt_b_in = cnt_b_ff + 1'b1;
            if (cnt_b_ff == '0) begin
               first_b_in = put_id;
            end
         end
      end

      // swap: new generation, exchange lists, empty the new next list; a wrap skips zero and sweeps marks
      if (swap_en) begin
         gen_in   = gen_ff + 1'b1;
         cur_b_in = !cur_b_ff;
         if (cur_b_ff) begin
            cnt_b_in = '0;
         end else begin
            cnt_a_in = '0;
         end
         if (gen_in == '0) begin
            gen_in   = GEN_BITS'(1);
            state_in = ST_SWEEP;
            sweep_in = '0;
         end
      end

      // clear then swap: bank b current, generation 2, marks swept
      if (clear_en) begin
         cur_b_in = 1'b1;
         cnt_a_in = '0;
         cnt_b_in = '0;
         gen_in   = GEN_BITS'(2);
         state_in = ST_SWEEP;
         sweep_in = '0;
      end

      // result from the post-operation state
      res_cc = cur_b_in ? cnt_b_in : cnt_a_in;
      res_nc = cur_b_in ? cnt_a_in : cnt_b_in;
      if (res_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.was_added     = res_added;
         rsp_in.current_count = res_cc;
         rsp_in.next_count    = res_nc;
         if (res_cc == '0) begin
            rsp_in.sync_state = SYNC_NONE;
         end else if (res_cc == CNT_W'(1)) begin
            rsp_in.sync_state = SYNC_ONE;
         end else begin
            rsp_in.sync_state = SYNC_MANY;
         end
         rsp_in.first_current = (res_cc == '0) ? '0 : (cur_b_in ? first_b_in : first_a_in);
         rsp_in.first_next    = (res_nc == '0) ? '0 : (cur_b_in ? first_a_in : first_b_in);
         rsp_in.read_value    = res_rval;
         rsp_in.read_valid    = res_rvalid;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         cur_b_ff     <= 1'b0;
         gen_ff       <= GEN_BITS'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cur_b_ff     <= cur_b_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      first_a_ff <= first_a_in;
      first_b_ff <= first_b_in;
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      elem_ff    <= elem_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // list counts never exceed capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(cnt_a_ff) <= ENTRY_COUNT) && (32'(cnt_b_ff) <= ENTRY_COUNT))
      else $error("list count beyond capacity");

   // generation zero is reserved for cleared marks
   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_ff != '0)
      else $error("generation reached zero");

   // a result is never written over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("result register overwritten");

   // no command is taken while marks are being swept
   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !cmd_take)
      else $error("command taken during mark sweep");

   // a put always finishes in the following cycle
   a_put_next: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && (cmd_data.kind == CMD_PUT)) |=> (state_ff == ST_PUT_WR))
      else $error("put did not reach write state");

endmodule

// ===== verif/double_buffered_dedup_set_unit_tb.sv =====
// Testbench for the dedup set unit: directed table plus random traffic, checked by a predictor.
module double_buffered_dedup_set_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dbds_pkg::*;

   localparam int CLK_HALF    = 10;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int MAX_REPORTS = 100;

   // Opcodes the block treats as no-ops
   localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd6;
   localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

   typedef struct packed {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   // Predicted set state
   logic [ID_W-1:0]     list_ids [2][ENTRY_COUNT];
   int                  list_len [2];
   bit                  cur_bank;
   logic [GEN_BITS-1:0] id_mark [ENTRY_COUNT];
   logic [GEN_BITS-1:0] gen_now;

   // Status words still owed by the block, oldest first
   rsp_type status_due [$];

   // Run bookkeeping
   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int checked;
   int cycles;
   int op_seen [8];
   int ids_added;
   int wrap_count;
   int peak_len;

   int phase_send_idle  [4] = '{0, 79, 0, 28};
   int phase_recv_stall [4] = '{0, 0, 79, 28};
   int phase_pool       [4] = '{31, 63, 255, 1023};

   dir_row_type dir_rows [25];

   double_buffered_dedup_set_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Append an id to the next list unless out of range, already marked this generation or the list is full
   function automatic bit set_insert(input int id);
      int nb;
      nb = 1 - int'(cur_bank);
      if (id >= ENTRY_COUNT) return 1'b0;
      if (id_mark[id] == gen_now) return 1'b0;
      if (list_len[nb] >= ENTRY_COUNT) return 1'b0;
      list_ids[nb][list_len[nb]] = ID_W'(id);
      list_len[nb]++;
      id_mark[id] = gen_now;
      return 1'b1;
   endfunction

   // Next generation (marks cleared and zero skipped on a wrap), flip banks, empty the new next list
   function automatic void set_advance();
      gen_now = gen_now + 1'b1;
      if (gen_now == '0) begin
         foreach (id_mark[i]) id_mark[i] = '0;
         gen_now = GEN_BITS'(1);
         wrap_count++;
      end
      cur_bank = ~cur_bank;
      list_len[1 - int'(cur_bank)] = 0;
   endfunction

   function automatic void set_wipe();
      cur_bank    = 1'b0;
      list_len[0] = 0;
      list_len[1] = 0;
      foreach (id_mark[i]) id_mark[i] = '0;
      gen_now = GEN_BITS'(1);
      set_advance();
   endfunction

   // Apply one request to the predicted set, return the status it yields
   function automatic rsp_type visited_set_step(input req_type item);
      rsp_type s;
      int      cb, nb, n, i;
      s  = '0;
      cb = int'(cur_bank);
      op_seen[item.opcode]++;
      case (item.opcode)
         OPC_PUT: s.was_added = set_insert(int'(item.entry_id));
         OPC_SWAP: set_advance();
         OPC_REMOVE: begin
            n = list_len[cb];
            for (i = 0; i < n; i++)
               if (list_ids[cb][i] != item.entry_id)
                  void'(set_insert(int'(list_ids[cb][i])));
            set_advance();
         end
         OPC_CLEAR: set_wipe();
         OPC_READ_CUR, OPC_READ_NEXT: begin
            nb = (item.opcode == OPC_READ_CUR) ? cb : 1 - cb;
            if (int'(item.read_index) < list_len[nb]) begin
               s.read_value = list_ids[nb][item.read_index];
               s.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
      cb = int'(cur_bank);
      nb = 1 - cb;
      s.current_count = CNT_W'(list_len[cb]);
      s.next_count    = CNT_W'(list_len[nb]);
      s.sync_state    = (list_len[cb] == 0) ? SYNC_NONE :
                        (list_len[cb] == 1) ? SYNC_ONE : SYNC_MANY;
      s.first_current = (list_len[cb] != 0) ? list_ids[cb][0] : '0;
      s.first_next    = (list_len[nb] != 0) ? list_ids[nb][0] : '0;
      if (s.was_added) ids_added++;
      if (list_len[cb] > peak_len) peak_len = list_len[cb];
      if (list_len[nb] > peak_len) peak_len = list_len[nb];
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type req_of(input logic [OPC_W-1:0] op, input int id,
                                      input int idx);
      req_type r;
      r.opcode     = op;
      r.entry_id   = ID_W'(id);
      r.read_index = ID_W'(idx);
      return r;
   endfunction

   function automatic rsp_type status_of(input bit added, input int cc, input int nc,
                                         input logic [SYNC_W-1:0] sync, input int fc,
                                         input int fn, input int rv, input bit rvld);
      rsp_type s;
      s.was_added     = added;
      s.current_count = CNT_W'(cc);
      s.next_count    = CNT_W'(nc);
      s.sync_state    = sync;
      s.first_current = ID_W'(fc);
      s.first_next    = ID_W'(fn);
      s.read_value    = ID_W'(rv);
      s.read_valid    = rvld;
      return s;
   endfunction

   // Mostly ids from a small pool so duplicates happen, some anywhere, a few extremes
   function automatic logic [ID_W-1:0] pick_id(input int pool_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return ($urandom_range(0, 1) != 0) ? ID_W'(ENTRY_COUNT - 1) : ID_W'(0);
      if (r < 20) return ID_W'($urandom_range(0, ENTRY_COUNT - 1));
      return ID_W'($urandom_range(0, pool_hi));
   endfunction

   // Random request shaped by the predicted state: reads mostly in range,
   // removes mostly of ids that are really in the current list
   function automatic req_type pick_item(input int pool_hi);
      req_type it;
      int      r, cb, nb;
      cb            = int'(cur_bank);
      nb            = 1 - cb;
      it.opcode     = OPC_PUT;
      it.entry_id   = pick_id(pool_hi);
      it.read_index = ID_W'($urandom_range(0, ENTRY_COUNT - 1));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         it.opcode = OPC_PUT;
      end else if (r < 57) begin
         it.opcode = OPC_READ_CUR;
         if (list_len[cb] > 0 && $urandom_range(0, 3) != 0)
            it.read_index = ID_W'($urandom_range(0, list_len[cb] - 1));
      end else if (r < 69) begin
         it.opcode = OPC_READ_NEXT;
         if (list_len[nb] > 0 && $urandom_range(0, 3) != 0)
            it.read_index = ID_W'($urandom_range(0, list_len[nb] - 1));
      end else if (r < 81) begin
         it.opcode = OPC_SWAP;
      end else if (r < 95) begin
         it.opcode = OPC_REMOVE;
         if (list_len[cb] > 0 && $urandom_range(0, 2) != 0)
            it.entry_id = list_ids[cb][$urandom_range(0, list_len[cb] - 1)];
      end else if (r < 97) begin
         it.opcode = OPC_CLEAR;
      end else begin
         it.opcode = ($urandom_range(0, 1) != 0) ? OPC_SPARE_HI : OPC_SPARE_LO;
      end
      return it;
   endfunction

   // One transfer into the block; called and returns at a falling edge
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predicted = visited_set_step(item);
      status_due.insert(status_due.size(), typed ? want : predicted);
      @(negedge clock);
   endtask

   // Hold off the sender until every owed status word has come back
   task automatic drain();
      req_push <= 1'b0;
      @(negedge clock);
      while (status_due.size() != 0) @(negedge clock);
   endtask

   // Put a few ids, run the generation once around the wrap, put them again:
   // the marks must have been cleared at the wrap so all go in again
   task automatic wrap_around();
      int i;
      for (i = 0; i < 16; i++) send_item(req_of(OPC_PUT, i, 0), 1'b0, '0);
      for (i = 0; i < (1 << GEN_BITS) - 1; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(req_of(OPC_READ_CUR, 0, $urandom_range(0, ENTRY_COUNT - 1)),
                      1'b0, '0);
         send_item(req_of(OPC_SWAP, 0, 0), 1'b0, '0);
      end
      for (i = 0; i < 16; i++) send_item(req_of(OPC_PUT, i, 0), 1'b0, '0);
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   function automatic void field_check(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t ns: mismatch in %s: expected %0d, actual %0d",
                     $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_status(input rsp_type want, input rsp_type got);
      field_check("was_added",     want.was_added,     got.was_added);
      field_check("current_count", want.current_count, got.current_count);
      field_check("next_count",    want.next_count,    got.next_count);
      field_check("sync_state",    want.sync_state,    got.sync_state);
      field_check("first_current", want.first_current, got.first_current);
      field_check("first_next",    want.first_next,    got.first_next);
      field_check("read_value",    want.read_value,    got.read_value);
      field_check("read_valid",    want.read_valid,    got.read_valid);
      checked++;
   endfunction

   // Result side: stall at random, check each transfer out
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (status_due.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t ns: mismatch: status word with none expected, actual %h",
                        $time, rsp_data);
            mismatches++;
         end else begin
            check_status(status_due.pop_front(), rsp_data);
         end
      end
   end

   // Watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d status words still owed",
               cycles, status_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int ph, k;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches     = 0;
      checked        = 0;
      ids_added      = 0;
      wrap_count     = 0;
      peak_len       = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      set_wipe();
      cur_bank = 1'b0;

      // Directed rows; typed expectations only where obvious
      dir_rows = '{
         '{req_of(OPC_READ_CUR, 0, 0), 1'b1,
           status_of(0, 0, 0, SYNC_NONE, 0, 0, 0, 0)},
         '{req_of(OPC_READ_NEXT, 1023, 1023), 1'b1,
           status_of(0, 0, 0, SYNC_NONE, 0, 0, 0, 0)},
         '{req_of(OPC_PUT, 1023, 0), 1'b1,
           status_of(1, 0, 1, SYNC_NONE, 0, 1023, 0, 0)},
         '{req_of(OPC_PUT, 1023, 0), 1'b1,
           status_of(0, 0, 1, SYNC_NONE, 0, 1023, 0, 0)},
         '{req_of(OPC_PUT, 0, 1023), 1'b1,
           status_of(1, 0, 2, SYNC_NONE, 0, 1023, 0, 0)},
         '{req_of(OPC_PUT, 682, 341), 1'b0, '0},
         '{req_of(OPC_PUT, 341, 682), 1'b0, '0},
         '{req_of(OPC_READ_NEXT, 0, 1), 1'b0, '0},
         '{req_of(OPC_READ_NEXT, 0, 4), 1'b0, '0},       // index equal to count
         '{req_of(OPC_SWAP, 0, 0), 1'b0, '0},
         '{req_of(OPC_PUT, 1023, 0), 1'b0, '0},          // new generation, goes in again
         '{req_of(OPC_READ_CUR, 0, 3), 1'b0, '0},
         '{req_of(OPC_READ_CUR, 0, 1023), 1'b0, '0},
         '{req_of(OPC_REMOVE, 0, 0), 1'b0, '0},          // next already holds one id
         '{req_of(OPC_REMOVE, 999, 0), 1'b0, '0},        // id not in the list
         '{req_of(OPC_SPARE_LO, 0, 0), 1'b0, '0},
         '{req_of(OPC_SPARE_HI, 1023, 1023), 1'b0, '0},
         '{req_of(OPC_SWAP, 0, 0), 1'b0, '0},
         '{req_of(OPC_PUT, 5, 0), 1'b0, '0},
         '{req_of(OPC_SWAP, 0, 0), 1'b0, '0},            // single entry current
         '{req_of(OPC_REMOVE, 5, 0), 1'b0, '0},
         '{req_of(OPC_REMOVE, 5, 0), 1'b0, '0},          // remove on an empty list
         '{req_of(OPC_CLEAR, 0, 0), 1'b1,
           status_of(0, 0, 0, SYNC_NONE, 0, 0, 0, 0)},
         '{req_of(OPC_PUT, 1023, 0), 1'b1,
           status_of(1, 0, 1, SYNC_NONE, 0, 1023, 0, 0)},
         '{req_of(OPC_READ_NEXT, 0, 0), 1'b0, '0}
      };

      // Reset, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      drain();

      // Random traffic, one idling mix per phase, sender paused between phases
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = phase_send_idle[ph];
         recv_stall_pct = phase_recv_stall[ph];
         for (k = 0; k < 240; k++) send_item(pick_item(phase_pool[ph]), 1'b0, '0);
         drain();
      end
      wrap_around();
      drain();

      // Let anything stray come out before closing
      recv_stall_pct = 0;
      repeat (40) @(negedge clock);

      $display("run: %0d status words checked; put %0d, swap %0d, remove %0d, %s",
               checked, op_seen[OPC_PUT], op_seen[OPC_SWAP], op_seen[OPC_REMOVE],
               $sformatf("clear %0d, reads %0d, spare ops %0d", op_seen[OPC_CLEAR],
                         op_seen[OPC_READ_CUR] + op_seen[OPC_READ_NEXT],
                         op_seen[OPC_SPARE_LO] + op_seen[OPC_SPARE_HI]));
      $display("run: %0d ids added by put, %0d generation wraps, %s",
               ids_added, wrap_count,
               $sformatf("longest list %0d, %0d mismatches", peak_len, mismatches));
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
